// ===== design/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and codes shared by the text console cell writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  char_code;
        logic [7:0]  scan_code;
        logic [10:0] cell_index;
    } tcw_in_t;

    typedef struct packed {
        logic [10:0] cursor_position;
        logic        in_command_mode;
        logic        command_submitted;
        logic [15:0] cell_value;
    } tcw_out_t;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_KEY   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [7:0] CHAR_SPECIAL   = 8'd0;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_PROMPT    = 8'h3E;

    localparam logic [7:0] SCAN_UP    = 8'h48;
    localparam logic [7:0] SCAN_DOWN  = 8'h50;
    localparam logic [7:0] SCAN_LEFT  = 8'h4B;
    localparam logic [7:0] SCAN_RIGHT = 8'h4D;

    localparam logic [7:0] ATTR_RESET = 8'h07;

    typedef logic [3:0] op_t;
    localparam op_t OP_PUT     = 4'd0;
    localparam op_t OP_NEWLINE = 4'd1;
    localparam op_t OP_CLEAR   = 4'd2;
    localparam op_t OP_READ    = 4'd3;
    localparam op_t OP_ENTER   = 4'd4;
    localparam op_t OP_BACK    = 4'd5;
    localparam op_t OP_ARROW   = 4'd6;
    localparam op_t OP_KCHAR   = 4'd7;
    localparam op_t OP_NONE    = 4'd8;

    typedef logic [1:0] dir_t;
    localparam dir_t DIR_UP    = 2'd0;
    localparam dir_t DIR_DOWN  = 2'd1;
    localparam dir_t DIR_LEFT  = 2'd2;
    localparam dir_t DIR_RIGHT = 2'd3;

    typedef struct packed {
        op_t         op;
        logic [7:0]  ch;
        dir_t        dir;
        logic [10:0] cell_addr;
    } tcw_cmd_t;

endpackage

// ===== design/tcw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front
// Accepts items, decodes them into commands and queues them for the back end.
// ----------------------------------------------------------------------------
module tcw_front
    import tcw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  tcw_in_t  in_item,
    input  logic     run_en,
    output logic     cmd_valid,
    output tcw_cmd_t cmd,
    input  logic     cmd_pop
);

    tcw_cmd_t   queue_mem [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       push;
    tcw_cmd_t   dec;

    assign in_stall  = (count_reg == 2'd2) || !run_en;
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = queue_mem[rd_ptr_reg];

    always_comb
    begin
        dec.op        = OP_NONE;
        dec.ch        = in_item.char_code;
        dec.dir       = DIR_UP;
        dec.cell_addr = in_item.cell_index;
        unique case (in_item.func)
            FUNC_WRITE:
            begin
                dec.op = (in_item.char_code == CHAR_NEWLINE) ? OP_NEWLINE : OP_PUT;
            end
            FUNC_KEY:
            begin
                case (in_item.char_code)
                    CHAR_NEWLINE:   dec.op = OP_ENTER;
                    CHAR_BACKSPACE: dec.op = OP_BACK;
                    CHAR_SPECIAL:
                    begin
                        dec.op = OP_ARROW;
                        case (in_item.scan_code)
                            SCAN_UP:    dec.dir = DIR_UP;
                            SCAN_DOWN:  dec.dir = DIR_DOWN;
                            SCAN_LEFT:  dec.dir = DIR_LEFT;
                            SCAN_RIGHT: dec.dir = DIR_RIGHT;
                            default:    dec.op  = OP_NONE;
                        endcase
                    end
                    default:        dec.op = OP_KCHAR;
                endcase
            end
            FUNC_CLEAR: dec.op = OP_CLEAR;
            FUNC_READ:  dec.op = OP_READ;
            default:    dec.op = OP_NONE;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !cmd_pop)
            count_next = count_reg + 2'd1;
        else if (!push && cmd_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_mem[wr_ptr_reg] <= dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (cmd_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

endmodule

// ===== design/tcw_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back
// Executes commands against the screen store and cursor, registers results.
// ----------------------------------------------------------------------------
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    input  tcw_cmd_t cmd,
    output logic     cmd_pop,
    output logic     run_en,
    input  logic [7:0] text_attribute,
    output logic     out_valid,
    input  logic     out_stall,
    output tcw_out_t out_item
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_FIN   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;

    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

    logic [7:0]    screen_mem [CELLS];
    logic [7:0]    rd_data_reg;

    logic [2:0]    state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic          cmd_mode_reg, cmd_mode_next;
    logic [AW-1:0] sweep_addr_reg, sweep_addr_next;
    logic [AW-1:0] sweep_end_reg, sweep_end_next;
    logic          emit_reg, emit_next;
    logic          prompt_reg, prompt_next;
    logic          submit_reg, submit_next;
    logic          in_range_reg, in_range_next;
    logic          out_valid_reg;
    tcw_out_t      out_reg;

    logic          out_ready;
    logic          emit;
    logic [15:0]   emit_value;
    logic          emit_submit;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] cur_idx;
    logic [AW-1:0] row_base;
    logic [RW-1:0] bs_row;
    logic [CW-1:0] bs_col;
    logic [31:0]   pos_next;

    assign out_ready = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign run_en    = !(state_reg == S_SWEEP && !emit_reg);

    assign row_base = AW'(32'(row_reg) * 32'(COLUMNS));
    assign cur_idx  = row_base + AW'(col_reg);

    // Step back one cell; hold at the top left.
    always_comb
    begin
        bs_row = row_reg;
        bs_col = col_reg;
        if (col_reg != '0)
            bs_col = col_reg - 1'b1;
        else if (row_reg != '0)
        begin
            bs_row = row_reg - 1'b1;
            bs_col = COL_LAST;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        cmd_mode_next   = cmd_mode_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_end_next  = sweep_end_reg;
        emit_next       = emit_reg;
        prompt_next     = prompt_reg;
        submit_next     = submit_reg;
        in_range_next   = in_range_reg;
        cmd_pop         = 1'b0;
        emit            = 1'b0;
        emit_value      = 16'd0;
        emit_submit     = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = cur_idx;
        wr_data         = CHAR_SPACE;
        rd_en           = 1'b0;
        rd_addr         = AW'(cmd.cell_addr);

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_ready)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_PUT, OP_KCHAR:
                        begin
                            emit = 1'b1;
                            if ((cmd.op == OP_PUT || cmd_mode_reg) && row_reg != ROW_LAST)
                            begin
                                wr_en   = 1'b1;
                                wr_data = cmd.ch;
                                if (col_reg == COL_LAST)
                                begin
                                    col_next = '0;
                                    row_next = row_reg + 1'b1;
                                end
                                else
                                    col_next = col_reg + 1'b1;
                            end
                        end
                        OP_NEWLINE:
                        begin
                            sweep_addr_next = cur_idx;
                            sweep_end_next  = row_base + AW'(COL_LAST);
                            emit_next       = 1'b1;
                            submit_next     = 1'b0;
                            prompt_next     = 1'b0;
                            state_next      = S_SWEEP;
                            col_next        = '0;
                            row_next        = (row_reg == ROW_LAST) ? '0 : row_reg + 1'b1;
                        end
                        OP_CLEAR, OP_ENTER:
                        begin
                            sweep_addr_next = '0;
                            sweep_end_next  = AW'(CELLS - 1);
                            emit_next       = 1'b1;
                            submit_next     = (cmd.op == OP_ENTER) && cmd_mode_reg;
                            prompt_next     = (cmd.op == OP_ENTER) && !cmd_mode_reg;
                            row_next        = '0;
                            col_next        = '0;
                            state_next      = S_SWEEP;
                            if (cmd.op == OP_ENTER)
                            begin
                                cmd_mode_next = !cmd_mode_reg;
                                if (!cmd_mode_reg)
                                    col_next = CW'(1);
                            end
                        end
                        OP_BACK:
                        begin
                            emit = 1'b1;
                            if (cmd_mode_reg)
                            begin
                                row_next = bs_row;
                                col_next = bs_col;
                                wr_en    = 1'b1;
                                wr_addr  = AW'(32'(bs_row) * 32'(COLUMNS)) + AW'(bs_col);
                            end
                        end
                        OP_ARROW:
                        begin
                            emit = 1'b1;
                            if (cmd_mode_reg)
                            begin
                                unique case (cmd.dir)
                                    DIR_UP:
                                        if (row_reg != '0) row_next = row_reg - 1'b1;
                                    DIR_DOWN:
                                        if (row_reg != ROW_LAST) row_next = row_reg + 1'b1;
                                    DIR_LEFT:
                                        if (col_reg != '0) col_next = col_reg - 1'b1;
                                    DIR_RIGHT:
                                        if (col_reg != COL_LAST) col_next = col_reg + 1'b1;
                                    default: ;
                                endcase
                            end
                        end
                        OP_READ:
                        begin
                            rd_en         = 1'b1;
                            in_range_next = (32'(cmd.cell_addr) < 32'(CELLS));
                            state_next    = S_READ;
                        end
                        default: emit = 1'b1;
                    endcase
                end
            end
            S_SWEEP:
            begin
                wr_en   = 1'b1;
                wr_addr = sweep_addr_reg;
                if (sweep_addr_reg == sweep_end_reg)
                    state_next = emit_reg ? S_FIN : S_IDLE;
                else
                    sweep_addr_next = sweep_addr_reg + 1'b1;
            end
            S_FIN:
            begin
                // Drop the prompt at the top left after the clear that enters command mode.
                if (prompt_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = CHAR_PROMPT;
                end
                if (out_ready)
                begin
                    emit        = 1'b1;
                    emit_submit = submit_reg;
                    prompt_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            S_READ:
            begin
                if (out_ready)
                begin
                    emit       = 1'b1;
                    emit_value = in_range_reg ? {text_attribute, rd_data_reg} : 16'd0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign pos_next = 32'(row_next) * 32'(COLUMNS) + 32'(col_next);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            screen_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= screen_mem[rd_addr];
        if (emit)
        begin
            out_reg.cursor_position   <= pos_next[10:0];
            out_reg.in_command_mode   <= cmd_mode_next;
            out_reg.command_submitted <= emit_submit;
            out_reg.cell_value        <= emit_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            row_reg        <= '0;
            col_reg        <= '0;
            cmd_mode_reg   <= 1'b0;
            sweep_addr_reg <= '0;
            sweep_end_reg  <= AW'(CELLS - 1);
            emit_reg       <= 1'b0;
            prompt_reg     <= 1'b0;
            submit_reg     <= 1'b0;
            in_range_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            cmd_mode_reg   <= cmd_mode_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_end_reg  <= sweep_end_next;
            emit_reg       <= emit_next;
            prompt_reg     <= prompt_next;
            submit_reg     <= submit_next;
            in_range_reg   <= in_range_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== design/text_console_cell_writer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer_core
// Text console: screen store of character codes, cursor and command mode.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on in_valid/in_stall and leave on out_valid/out_stall; each
//   item gives exactly one result. A two-entry queue decouples the decoder
//   from the execution sequencer, so items are taken while a result waits.
//   Flow: a plain character, key event or arrow is popped from the queue and
//   executed in S_IDLE, its result going to the output register; a read
//   goes through S_READ for the registered store read. Newline sweeps the
//   rest of the row; clear and Enter sweep the whole store; each gives its
//   result from S_FIN after the sweep. The queue takes new items meanwhile.
//   The single write port of the screen store makes each sweep write the
//   cells one by one. Reset: cursor, command mode and attribute (7) reset
//   at once; a clearing pass then fills the store with spaces, with in_stall
//   high. Configuration writes are taken at any time.
//   Receiver stall: the result holds in the output register; execution stops
//   at the next result and the queue fills, then in_stall rises.
// ----------------------------------------------------------------------------
module text_console_cell_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  tcw_in_t    in_item,
    output logic       out_valid,
    input  logic       out_stall,
    output tcw_out_t   out_item,
    input  logic       cfg_write_en,
    input  logic [7:0] cfg_write_data
);

    logic [7:0] attr_reg;
    logic       run_en;
    logic       cmd_valid;
    logic       cmd_pop;
    tcw_cmd_t   cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            attr_reg <= ATTR_RESET;
        else if (cfg_write_en)
            attr_reg <= cfg_write_data;
    end

    tcw_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .run_en    (run_en),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop),
        .run_en         (run_en),
        .text_attribute (attr_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_item       (out_item)
    );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Text console cell writer check: a directed table and then random items.
// The bench runs every accepted item through its own console model and
// compares each result field by field. Both sides idle at random, and the
// attribute register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import tcw_pkg::*;

    localparam int COLS        = 80;
    localparam int ROWCOUNT    = 25;
    localparam int CELLCOUNT   = COLS * ROWCOUNT;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int DRAIN_WAIT  = CELLCOUNT + 20;

    typedef struct {
        tcw_in_t  item;
        bit       typed;
        tcw_out_t want;
    } table_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    tcw_in_t    in_item;
    logic       out_valid;
    logic       out_stall;
    tcw_out_t   out_item;
    logic       cfg_write_en;
    logic [7:0] cfg_write_data;

    // console model state
    logic [7:0] screen [CELLCOUNT];
    int         cur_row;
    int         cur_col;
    bit         cmd_mode;
    logic [7:0] attr;

    tcw_out_t   pending_results[$];
    table_row_t directed[$];
    int         mismatches;
    int         cycles;
    bit         quiet;

    text_console_cell_writer_core #(.COLUMNS(COLS), .ROWS(ROWCOUNT)) dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_item       (out_item),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic report(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    function automatic void blank_screen();
        for (int i = 0; i < CELLCOUNT; i++)
            screen[i] = CHAR_SPACE;
        cur_row = 0;
        cur_col = 0;
    endfunction

    function automatic void write_char(input logic [7:0] c);
        int idx;
        if (c == CHAR_NEWLINE)
        begin
            for (int i = cur_row * COLS + cur_col; i < (cur_row + 1) * COLS && i < CELLCOUNT; i++)
                screen[i] = CHAR_SPACE;
            cur_row++;
            cur_col = 0;
        end
        else
        begin
            idx = cur_row * COLS + cur_col;
            // drop anything aimed at the last row
            if (idx >= (ROWCOUNT - 1) * COLS)
                return;
            screen[idx] = c;
            cur_col++;
        end
        if (cur_col >= COLS)
        begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= ROWCOUNT)
            cur_row = 0;
    endfunction

    function automatic bit console_key(input logic [7:0] c, input logic [7:0] sc);
        if (!cmd_mode)
        begin
            if (c == CHAR_NEWLINE)
            begin
                cmd_mode = 1'b1;
                blank_screen();
                write_char(CHAR_PROMPT);
            end
            return 1'b0;
        end
        if (c == CHAR_BACKSPACE)
        begin
            if (cur_col > 0)
                cur_col--;
            else if (cur_row > 0)
            begin
                cur_row--;
                cur_col = COLS - 1;
            end
            screen[cur_row * COLS + cur_col] = CHAR_SPACE;
        end
        else if (c == CHAR_SPECIAL)
        begin
            if (sc == SCAN_UP && cur_row > 0)
                cur_row--;
            else if (sc == SCAN_DOWN && cur_row < ROWCOUNT - 1)
                cur_row++;
            else if (sc == SCAN_LEFT && cur_col > 0)
                cur_col--;
            else if (sc == SCAN_RIGHT && cur_col < COLS - 1)
                cur_col++;
        end
        else if (c == CHAR_NEWLINE)
        begin
            cmd_mode = 1'b0;
            blank_screen();
            return 1'b1;
        end
        else
            write_char(c);
        return 1'b0;
    endfunction

    function automatic tcw_out_t console_step(input tcw_in_t it);
        tcw_out_t r;
        r = '0;
        case (it.func)
            FUNC_WRITE: write_char(it.char_code);
            FUNC_KEY:   r.command_submitted = console_key(it.char_code, it.scan_code);
            FUNC_CLEAR: blank_screen();
            default:
                if (it.cell_index < CELLCOUNT)
                    r.cell_value = {attr, screen[it.cell_index]};
        endcase
        r.cursor_position = 11'(cur_row * COLS + cur_col);
        r.in_command_mode = cmd_mode;
        return r;
    endfunction

    task automatic add_row(input logic [1:0] f, input logic [7:0] c, input logic [7:0] sc,
                           input logic [10:0] cell_idx, input bit typed, input tcw_out_t want);
        table_row_t row;
        row.item  = '{func: f, char_code: c, scan_code: sc, cell_index: cell_idx};
        row.typed = typed;
        row.want  = want;
        directed.push_back(row);
    endtask

    task automatic send_item(input tcw_in_t it, input bit typed, input tcw_out_t want);
        int gap;
        tcw_out_t predicted;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
        predicted = console_step(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_attribute(input logic [7:0] value);
        wait_drained();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        attr = value;
    endtask

    function automatic tcw_in_t random_item();
        tcw_in_t it;
        int pick;
        it.func       = FUNC_WRITE;
        it.char_code  = 8'($urandom_range(0, 255));
        it.scan_code  = 8'($urandom_range(0, 255));
        it.cell_index = 11'($urandom_range(0, 1999));
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            if ($urandom_range(0, 4) == 0)
                it.char_code = CHAR_NEWLINE;
        end
        else if (pick < 72)
        begin
            it.func = FUNC_KEY;
            pick = $urandom_range(0, 9);
            if (pick < 2)
                it.char_code = CHAR_NEWLINE;
            else if (pick < 4)
                it.char_code = CHAR_BACKSPACE;
            else if (pick < 7)
            begin
                it.char_code = CHAR_SPECIAL;
                case ($urandom_range(0, 4))
                    0: it.scan_code = SCAN_UP;
                    1: it.scan_code = SCAN_DOWN;
                    2: it.scan_code = SCAN_LEFT;
                    3: it.scan_code = SCAN_RIGHT;
                    default: ;
                endcase
            end
        end
        else if (pick < 75)
            it.func = FUNC_CLEAR;
        else
        begin
            it.func = FUNC_READ;
            if ($urandom_range(0, 7) == 0)
                it.cell_index = 11'($urandom_range(0, 2047));
        end
        return it;
    endfunction

    // result side: check each accepted item, then draw the next stall
    initial
    begin
        int stall_left;
        tcw_out_t want;
        stall_left = 0;
        out_stall  = 1'b1;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                    report("result with nothing expected");
                else
                begin
                    want = pending_results.pop_front();
                    if (out_item.cursor_position !== want.cursor_position)
                        report($sformatf("cursor_position %0d, expected %0d",
                                         out_item.cursor_position, want.cursor_position));
                    if (out_item.in_command_mode !== want.in_command_mode)
                        report($sformatf("in_command_mode %b, expected %b",
                                         out_item.in_command_mode, want.in_command_mode));
                    if (out_item.command_submitted !== want.command_submitted)
                        report($sformatf("command_submitted %b, expected %b",
                                         out_item.command_submitted, want.command_submitted));
                    if (out_item.cell_value !== want.cell_value)
                        report($sformatf("cell_value %h, expected %h",
                                         out_item.cell_value, want.cell_value));
                end
                stall_left = quiet ? 0 : $urandom_range(0, 19);
            end
            else if (stall_left > 0)
                stall_left--;
            out_stall <= (stall_left > 0);
        end
    end

    initial
    begin
        tcw_out_t none;
        tcw_out_t want;
        mismatches     = 0;
        quiet          = 1'b0;
        none           = '0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        attr           = ATTR_RESET;
        cmd_mode       = 1'b0;
        blank_screen();

        want = '{cursor_position: 11'd0, in_command_mode: 1'b0, command_submitted: 1'b0,
                 cell_value: {ATTR_RESET, CHAR_SPACE}};
        add_row(FUNC_READ, 8'h00, 8'h00, 11'd0, 1'b1, want);
        add_row(FUNC_READ, 8'hFF, 8'hFF, 11'd1999, 1'b1, want);
        add_row(FUNC_READ, 8'h00, 8'h00, 11'd2000, 1'b1, none);
        add_row(FUNC_READ, 8'h00, 8'h00, 11'd2047, 1'b1, none);
        add_row(FUNC_WRITE, 8'hFF, 8'h00, 11'd0, 1'b0, none);
        add_row(FUNC_WRITE, 8'h00, 8'hFF, 11'd0, 1'b0, none);
        add_row(FUNC_READ, 8'h00, 8'h00, 11'd0, 1'b0, none);
        add_row(FUNC_WRITE, CHAR_NEWLINE, 8'h00, 11'd0, 1'b0, none);
        add_row(FUNC_KEY, 8'h41, 8'h00, 11'd0, 1'b0, none);
        add_row(FUNC_KEY, CHAR_NEWLINE, 8'h00, 11'd0, 1'b0, none);
        add_row(FUNC_KEY, CHAR_BACKSPACE, 8'h00, 11'd0, 1'b0, none);
        add_row(FUNC_KEY, CHAR_BACKSPACE, 8'h00, 11'd0, 1'b0, none);
        add_row(FUNC_KEY, CHAR_SPECIAL, SCAN_UP, 11'd0, 1'b0, none);
        add_row(FUNC_KEY, CHAR_SPECIAL, SCAN_LEFT, 11'd0, 1'b0, none);
        add_row(FUNC_KEY, CHAR_SPECIAL, SCAN_DOWN, 11'd0, 1'b0, none);
        add_row(FUNC_KEY, CHAR_SPECIAL, SCAN_RIGHT, 11'd0, 1'b0, none);
        add_row(FUNC_KEY, CHAR_SPECIAL, 8'hFF, 11'd0, 1'b0, none);
        add_row(FUNC_KEY, 8'h7A, 8'h00, 11'd0, 1'b0, none);
        add_row(FUNC_READ, 8'h00, 8'h00, 11'd81, 1'b0, none);
        want = '{cursor_position: 11'd0, in_command_mode: 1'b0, command_submitted: 1'b1,
                 cell_value: 16'd0};
        add_row(FUNC_KEY, CHAR_NEWLINE, 8'h00, 11'd0, 1'b1, want);
        add_row(FUNC_WRITE, 8'h33, 8'h00, 11'd0, 1'b0, none);
        add_row(FUNC_CLEAR, 8'h00, 8'h00, 11'd0, 1'b0, none);
        add_row(FUNC_READ, 8'h00, 8'h00, 11'd0, 1'b0, none);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_item(directed[i].item, directed[i].typed, directed[i].want);

        for (int n = 0; n < 740; n++)
        begin
            case (n)
                0:   set_attribute(8'h00);
                250: set_attribute(8'hFF);
                500: set_attribute(8'($urandom_range(1, 254)));
                default: ;
            endcase
            if (n == 400)
                wait_drained();
            // toggle stretches of back-to-back traffic
            if (n % 100 == 60)
                quiet = 1'b1;
            else if (n % 100 == 90)
                quiet = 1'b0;
            send_item(random_item(), 1'b0, none);
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== text_console_cell_writer_core.f =====
design/tcw_pkg.sv
design/tcw_front.sv
design/tcw_back.sv
design/text_console_cell_writer_core.sv
bench/testbench.sv
